// ----- src/cse_pkg.sv -----
// shared types, codes and helpers of the can signal extract/insert block
package cse_pkg;

  // frame geometry
  localparam int FRAME_BYTES_DEF = 8;
  localparam int BYTE_W          = 8;
  localparam int FRAME_W         = 64;
  localparam int WIDE_W          = 2 * FRAME_W;
  localparam int LEN_W           = 7;
  localparam int MAX_LEN         = 64;
  localparam int SH_W            = 8;
  localparam int SCALE_W         = 32;
  localparam int QUEUE_DEPTH     = 2;

  // operation codes
  localparam logic OP_EXTRACT = 1'b0;
  localparam logic OP_INSERT  = 1'b1;

  // item kinds after classification
  localparam logic [1:0] KIND_PASS    = 2'd0;
  localparam logic [1:0] KIND_EXTRACT = 2'd1;
  localparam logic [1:0] KIND_INSERT  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SAT    = 2'd1;
  localparam logic [1:0] ST_ZSCALE = 2'd2;

  // register indexes
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_START_BIT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SIG_LENGTH = 3'd1;
  localparam logic [IDX_W-1:0] REG_BIG_ENDIAN = 3'd2;
  localparam logic [IDX_W-1:0] REG_SIGNED_RAW = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCALE      = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFFSET     = 3'd5;

  // reset value of scale: 1.0 in Q16.16
  localparam logic signed [SCALE_W-1:0] SCALE_ONE = 32'sd65536;

  typedef struct packed {
    logic [5:0]               start_bit;
    logic [LEN_W-1:0]         signal_length;
    logic                     big_endian;
    logic                     signed_raw;
    logic signed [SCALE_W-1:0] scale;
    logic signed [FRAME_W-1:0] offset;
  } cse_cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         status;
    logic [FRAME_W-1:0] frame;
    logic [WIDE_W-1:0]  word;
    logic [SH_W-1:0]    shift;
    logic [FRAME_W-1:0] mask;
    logic               moto;
    logic               dneg;
    logic [FRAME_W-1:0] dmag;
  } cse_job_t;

  // reverse the byte order of a frame
  function automatic logic [FRAME_W-1:0] bswap64(input logic [FRAME_W-1:0] d);
    logic [FRAME_W-1:0] r;
    r = '0;
    for (int b = 0; b < FRAME_W / BYTE_W; b++) begin
      r[b*BYTE_W +: BYTE_W] = d[(FRAME_W/BYTE_W-1-b)*BYTE_W +: BYTE_W];
    end
    return r;
  endfunction

  // keep the masked low bits, sign-extend from the top one when signed
  function automatic logic [FRAME_W-1:0] sext64(input logic [FRAME_W-1:0] raw,
                                                input logic [FRAME_W-1:0] mask,
                                                input logic sgn);
    logic [FRAME_W-1:0] top;
    top = mask ^ (mask >> 1);
    if (sgn && ((raw & top) != '0)) begin
      return raw | ~mask;
    end
    return raw & mask;
  endfunction

endpackage

// ----- src/cse_in_if.sv -----
// input channel of the can signal extract/insert block
interface cse_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] frame_in;
  logic signed [63:0] phys_value;

  modport source (output valid, output operation, output frame_in, output phys_value,
                  input ready);
  modport sink (input valid, input operation, input frame_in, input phys_value,
                output ready);
endinterface

// ----- src/cse_out_if.sv -----
// result channel of the can signal extract/insert block
interface cse_out_if;
  logic        valid;
  logic        ready;
  logic signed [63:0] phys_out;
  logic [63:0] raw_out;
  logic [63:0] frame_out;
  logic [1:0]  status;

  modport source (output valid, output phys_out, output raw_out, output frame_out,
                  output status, input ready);
  modport sink (input valid, input phys_out, input raw_out, input frame_out,
                input status, output ready);
endinterface

// ----- src/can_signal_extract_insert_core.sv -----
// top level of the can signal extract/insert block
// Reads one configured CAN signal out of an 8-byte frame, or writes a
// physical value into it, Intel or Motorola bit order.
// in_item: operation, frame_in, phys_value; taken when valid and ready.
// out_item: phys_out, raw_out, frame_out, status; one item per input item,
// in order, held stable until ready.
// cfg_we/cfg_index/cfg_data write the signal registers; write only while idle.
// Extract runs bit gather, two 32x32 partial products on one multiplier,
// combine and offset add in turn; insert runs the one-bit-per-cycle 64/32
// divider, then sign handling and the frame write; a zero-length item or a
// zero-scale insert goes straight to the result. The back end works on one
// item at a time, so it takes no new item until the last one is out.
// A two-entry queue keeps accepting items while the back end works, and the
// result register lets the back end finish an item while the receiver
// stalls; a stalled receiver finally stops the back end, then the queue.
// Reset (rst, synchronous) empties queue and result register and loads the
// registers: start 0, length 0, Intel, unsigned, scale 1.0, offset 0.
module can_signal_extract_insert_core #(
  parameter int FRAME_BYTES = cse_pkg::FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH = cse_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  cse_in_if.sink                      in_item,
  cse_out_if.source                   out_item,
  input  logic                        cfg_we,
  input  logic [cse_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cse_pkg::FRAME_W-1:0] cfg_data
);
  import cse_pkg::*;

  cse_cfg_t cfg;
  cse_job_t front_job;
  cse_job_t q_job;
  logic     q_ready;
  logic     q_valid;
  logic     q_pop;
  logic     push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_bit     <= '0;
      cfg.signal_length <= '0;
      cfg.big_endian    <= 1'b0;
      cfg.signed_raw    <= 1'b0;
      cfg.scale         <= SCALE_ONE;
      cfg.offset        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BIT:  cfg.start_bit     <= cfg_data[5:0];
        REG_SIG_LENGTH: cfg.signal_length <= cfg_data[LEN_W-1:0];
        REG_BIG_ENDIAN: cfg.big_endian    <= cfg_data[0];
        REG_SIGNED_RAW: cfg.signed_raw    <= cfg_data[0];
        REG_SCALE:      cfg.scale         <= cfg_data[SCALE_W-1:0];
        REG_OFFSET:     cfg.offset        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.ready = q_ready;
  assign push          = in_item.valid && q_ready;

  cse_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .operation  (in_item.operation),
    .frame_in   (in_item.frame_in),
    .phys_value (in_item.phys_value),
    .cfg        (cfg),
    .job        (front_job)
  );

  cse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .ready    (q_ready),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_job  (q_job)
  );

  cse_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .phys_out  (out_item.phys_out),
    .raw_out   (out_item.raw_out),
    .frame_out (out_item.frame_out),
    .status    (out_item.status)
  );

endmodule

// ----- src/cse_front.sv -----
// front end: classifies an incoming item and lays out the signal geometry
module cse_front #(
  parameter int FRAME_BYTES = cse_pkg::FRAME_BYTES_DEF
) (
  input  logic                         operation,
  input  logic [cse_pkg::FRAME_W-1:0]  frame_in,
  input  logic signed [cse_pkg::FRAME_W-1:0] phys_value,
  input  cse_pkg::cse_cfg_t            cfg,
  output cse_pkg::cse_job_t            job
);
  import cse_pkg::*;

  localparam logic [FRAME_W-1:0] AREA = {FRAME_W{1'b1}} >> (FRAME_W - FRAME_BYTES * BYTE_W);
  localparam logic [SH_W-1:0]    WIDE_SH = SH_W'(WIDE_W);

  logic [LEN_W-1:0]   len;
  logic [FRAME_W-1:0] mask;
  logic [FRAME_W-1:0] dview;
  logic [5:0]         mstart;
  logic [FRAME_W:0]   diff;

  always_comb begin
    // clamp length, build mask
    len    = (cfg.signal_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : cfg.signal_length;
    mask   = (len == LEN_W'(MAX_LEN)) ? '1 : ((FRAME_W'(1) << len) - FRAME_W'(1));
    // motorola msb position in the byte-swapped view
    mstart = cfg.start_bit ^ 6'd7;
    dview  = cfg.big_endian ? bswap64(frame_in & AREA) : (frame_in & AREA);
    // difference to offset for insert
    diff   = {phys_value[FRAME_W-1], phys_value} - {cfg.offset[FRAME_W-1], cfg.offset};

    job.frame = frame_in;
    job.mask  = mask;
    job.moto  = cfg.big_endian;
    if (cfg.big_endian) begin
      job.word  = {dview, {FRAME_W{1'b0}}};
      job.shift = WIDE_SH - {2'b00, mstart} - {1'b0, len};
    end else begin
      job.word  = {{FRAME_W{1'b0}}, dview};
      job.shift = {2'b00, cfg.start_bit};
    end
    job.dneg = diff[FRAME_W];
    job.dmag = diff[FRAME_W] ? (FRAME_W'(0) - diff[FRAME_W-1:0]) : diff[FRAME_W-1:0];

    // classify
    job.status = ST_OK;
    if (len == '0) begin
      job.kind = KIND_PASS;
    end else if (operation == OP_INSERT) begin
      if (cfg.scale == '0) begin
        job.kind   = KIND_PASS;
        job.status = ST_ZSCALE;
      end else begin
        job.kind = KIND_INSERT;
      end
    end else begin
      job.kind = KIND_EXTRACT;
    end
  end

endmodule

// ----- src/cse_queue.sv -----
// short queue between front and back
module cse_queue #(
  parameter int DEPTH = cse_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cse_pkg::cse_job_t push_job,
  output logic              ready,
  output logic              valid,
  input  logic              pop,
  output cse_pkg::cse_job_t pop_job
);
  import cse_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cse_job_t           mem [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;

  assign ready   = (count != CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign pop_job = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- src/cse_back.sv -----
// back end: gathers bits, scales, divides, writes the frame and holds the result
module cse_back #(
  parameter int FRAME_BYTES = cse_pkg::FRAME_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cse_pkg::cse_cfg_t                  cfg,
  input  logic                               q_valid,
  input  cse_pkg::cse_job_t                  q_job,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cse_pkg::FRAME_W-1:0] phys_out,
  output logic [cse_pkg::FRAME_W-1:0]        raw_out,
  output logic [cse_pkg::FRAME_W-1:0]        frame_out,
  output logic [1:0]                         status
);
  import cse_pkg::*;

  localparam logic [FRAME_W-1:0] AREA = {FRAME_W{1'b1}} >> (FRAME_W - FRAME_BYTES * BYTE_W);
  localparam int HALF_W = FRAME_W / 2;
  localparam int MAG_W  = FRAME_W + SCALE_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_XRAW  = 4'd1;
  localparam logic [3:0] S_XMUL0 = 4'd2;
  localparam logic [3:0] S_XMUL1 = 4'd3;
  localparam logic [3:0] S_XSUM  = 4'd4;
  localparam logic [3:0] S_XOUT  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_IRAW  = 4'd7;
  localparam logic [3:0] S_IOUT  = 4'd8;
  localparam logic [3:0] S_POUT  = 4'd9;

  logic [3:0]          state;
  cse_job_t            job;
  logic [FRAME_W-1:0]  rawv;
  logic                rneg;
  logic [FRAME_W-1:0]  mag;
  logic [FRAME_W-1:0]  acc;
  logic [FRAME_W-1:0]  prod;
  logic signed [WIDE_W-1:0] psum;
  logic [FRAME_W-1:0]  dq;
  logic [SCALE_W-1:0]  rem;
  logic [5:0]          cnt;
  logic [1:0]          istat;

  logic                sneg;
  logic [SCALE_W-1:0]  smag;
  logic                ofree;
  logic [HALF_W-1:0]   mul_a;
  logic [FRAME_W-1:0]  mul_p;
  logic [WIDE_W-1:0]   shifted;
  logic [FRAME_W-1:0]  rx;
  logic [FRAME_W-1:0]  rs;
  logic [MAG_W-1:0]    mag96;
  logic signed [WIDE_W-1:0] sum;
  logic                sat;
  logic [SCALE_W:0]    rsh;
  logic                ge;
  logic                clamp;
  logic [WIDE_W-1:0]   ins_m;
  logic [WIDE_W-1:0]   ins_v;
  logic [WIDE_W-1:0]   wnew;
  logic [FRAME_W-1:0]  dnew;
  logic [FRAME_W-1:0]  fnew;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign ofree = !out_valid || out_ready;

  // scale magnitude and shared multiplier
  always_comb begin
    sneg  = cfg.scale[SCALE_W-1];
    smag  = sneg ? (SCALE_W'(0) - cfg.scale) : cfg.scale;
    mul_a = (state == S_XMUL0) ? mag[HALF_W-1:0] : mag[FRAME_W-1:HALF_W];
    mul_p = mul_a * smag;
  end

  // bit gather and sign extension
  always_comb begin
    shifted = job.word >> job.shift;
    rx      = shifted[FRAME_W-1:0] & job.mask;
    rs      = sext64(rx, job.mask, cfg.signed_raw);
  end

  // product combine and offset add with saturation
  always_comb begin
    mag96 = {{SCALE_W{1'b0}}, acc} + {prod, {HALF_W{1'b0}}};
    sum   = psum + {{FRAME_W{cfg.offset[FRAME_W-1]}}, cfg.offset};
    sat   = (sum[WIDE_W-1:FRAME_W-1] != '0) && (sum[WIDE_W-1:FRAME_W-1] != '1);
  end

  // one restoring division step
  always_comb begin
    rsh = {rem, dq[FRAME_W-1]};
    ge  = (rsh >= {1'b0, smag});
  end

  // quotient sign handling and frame write
  always_comb begin
    clamp = (dq != '0) && (job.dneg != sneg);
    ins_m = {{FRAME_W{1'b0}}, job.mask} << job.shift;
    ins_v = {{FRAME_W{1'b0}}, rawv & job.mask} << job.shift;
    wnew  = (job.word & ~ins_m) | ins_v;
    dnew  = job.moto ? wnew[WIDE_W-1:FRAME_W] : wnew[FRAME_W-1:0];
    fnew  = job.moto ? bswap64(dnew) : dnew;
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_job.kind)
              KIND_EXTRACT: state <= S_XRAW;
              KIND_INSERT:  state <= S_DIV;
              default:      state <= S_POUT;
            endcase
          end
        end
        S_XRAW:  state <= S_XMUL0;
        S_XMUL0: state <= S_XMUL1;
        S_XMUL1: state <= S_XSUM;
        S_XSUM:  state <= S_XOUT;
        S_DIV: begin
          if (cnt == '1) begin
            state <= S_IRAW;
          end
        end
        S_IRAW: state <= S_IOUT;
        S_XOUT, S_IOUT, S_POUT: begin
          if (ofree) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        job <= q_job;
        dq  <= q_job.dmag;
        rem <= '0;
        cnt <= '0;
      end
      S_XRAW: begin
        rawv <= rs;
        rneg <= cfg.signed_raw && rs[FRAME_W-1];
        mag  <= (cfg.signed_raw && rs[FRAME_W-1]) ? (FRAME_W'(0) - rs) : rs;
      end
      S_XMUL0: prod <= mul_p;
      S_XMUL1: begin
        acc  <= prod;
        prod <= mul_p;
      end
      S_XSUM: begin
        psum <= (rneg != sneg) ? (WIDE_W'(0) - {{(WIDE_W-MAG_W){1'b0}}, mag96})
                               : {{(WIDE_W-MAG_W){1'b0}}, mag96};
      end
      S_DIV: begin
        rem <= ge ? SCALE_W'(rsh - {1'b0, smag}) : rsh[SCALE_W-1:0];
        dq  <= {dq[FRAME_W-2:0], ge};
        cnt <= cnt + 6'd1;
      end
      S_IRAW: begin
        istat <= ST_OK;
        if (clamp) begin
          if (cfg.signed_raw) begin
            rawv <= FRAME_W'(0) - dq;
          end else begin
            rawv  <= '0;
            istat <= ST_SAT;
          end
        end else begin
          rawv <= dq;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_XOUT || state == S_IOUT || state == S_POUT) && ofree) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ofree) begin
      case (state)
        S_XOUT: begin
          raw_out   <= rawv;
          frame_out <= job.frame;
          if (sat) begin
            phys_out <= sum[WIDE_W-1] ? {1'b1, {(FRAME_W-1){1'b0}}}
                                      : {1'b0, {(FRAME_W-1){1'b1}}};
            status   <= ST_SAT;
          end else begin
            phys_out <= sum[FRAME_W-1:0];
            status   <= ST_OK;
          end
        end
        S_IOUT: begin
          phys_out  <= '0;
          raw_out   <= sext64(rawv, job.mask, cfg.signed_raw);
          frame_out <= (job.frame & ~AREA) | (fnew & AREA);
          status    <= istat;
        end
        S_POUT: begin
          phys_out  <= '0;
          raw_out   <= '0;
          frame_out <= job.frame;
          status    <= job.status;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- src/cse_checker.sv -----
// port checks of the can signal extract/insert block and their binding
module cse_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] phys_out,
  input logic [63:0] raw_out,
  input logic [63:0] frame_out,
  input logic [1:0]  status
);
  import cse_pkg::*;

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_out) && $stable(raw_out))
    else $error("stalled result changed");

  // zero scale insert writes nothing
  a_zscale: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ZSCALE |-> raw_out == '0 && phys_out == '0)
    else $error("zero scale result not empty");

  // saturated extract sits at a rail
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_SAT && phys_out != '0 |->
      phys_out == 64'h8000000000000000 || phys_out == 64'h7fffffffffffffff)
    else $error("saturated value not at a rail");

  // unused status code never shows
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_SAT || status == ST_ZSCALE)
    else $error("bad status code");

endmodule

bind can_signal_extract_insert_core cse_checker u_cse_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .phys_out  (out_item.phys_out),
  .raw_out   (out_item.raw_out),
  .frame_out (out_item.frame_out),
  .status    (out_item.status)
);

// ----- bench/cse_checker.sv -----
// checker: predicts each result item of the signal extract/insert block and compares
`timescale 1ns / 100ps
module cse_scoreboard (
  input  logic        clk,
  input  logic        rst,
  cse_in_if.sink      in_item,
  cse_out_if.sink     out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import cse_pkg::*;

  typedef struct packed {
    logic [63:0] phys;
    logic [63:0] raw;
    logic [63:0] frame;
    logic [1:0]  status;
  } signal_result_t;

  cse_cfg_t sig_cfg;
  signal_result_t expected_q[$];

  assign pending = expected_q.size();

  // frame position of signal bit i, -1 when outside the frame
  function automatic int bit_position(input int i);
    int byte_no, bit_no, m;
    if (!sig_cfg.big_endian) begin
      byte_no = (int'(sig_cfg.start_bit) + i) / 8;
      bit_no  = (int'(sig_cfg.start_bit) + i) % 8;
    end else begin
      m = (int'(sig_cfg.start_bit) / 8) * 8 + (7 - int'(sig_cfg.start_bit) % 8) + i;
      byte_no = m / 8;
      bit_no  = 7 - m % 8;
    end
    if (byte_no >= 8) return -1;
    return byte_no * 8 + bit_no;
  endfunction

  function automatic logic [63:0] widen_raw(input logic [63:0] raw, input int len);
    logic [63:0] msk;
    msk = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
    raw &= msk;
    if (sig_cfg.signed_raw && len < 64 && raw[len-1]) raw |= ~msk;
    return raw;
  endfunction

  function automatic signal_result_t predict_signal(input logic op, input logic [63:0] frame,
                                                    input logic signed [63:0] value);
    signal_result_t r;
    int len, pos, idx;
    logic [63:0] raw;
    logic signed [127:0] wide, lim_hi, lim_lo;
    logic signed [64:0] diff;
    logic [64:0] dmag;
    logic [63:0] q;
    logic [32:0] smag;
    logic dneg, sneg;
    r = '{phys: '0, raw: '0, frame: frame, status: ST_OK};
    len = (sig_cfg.signal_length > 64) ? 64 : int'(sig_cfg.signal_length);
    if (len == 0) return r;
    if (op == OP_EXTRACT) begin
      raw = '0;
      for (int i = 0; i < len; i++) begin
        pos = bit_position(i);
        idx = sig_cfg.big_endian ? len - 1 - i : i;
        if (pos >= 0 && frame[pos]) raw[idx] = 1'b1;
      end
      raw = widen_raw(raw, len);
      r.raw = raw;
      if (sig_cfg.signed_raw) wide = $signed(raw);
      else wide = $signed({64'd0, raw});
      wide = wide * $signed(sig_cfg.scale) + $signed(sig_cfg.offset);
      lim_hi = 128'sh7FFF_FFFF_FFFF_FFFF;
      lim_lo = -lim_hi - 1;
      if (wide > lim_hi) begin
        r.phys = 64'h7FFF_FFFF_FFFF_FFFF; r.status = ST_SAT;
      end else if (wide < lim_lo) begin
        r.phys = 64'h8000_0000_0000_0000; r.status = ST_SAT;
      end else r.phys = wide[63:0];
    end else begin
      if (sig_cfg.scale == 0) begin
        r.status = ST_ZSCALE;
        return r;
      end
      sneg = sig_cfg.scale[31];
      smag = sneg ? 33'h1_0000_0000 - {1'b0, sig_cfg.scale} : {1'b0, sig_cfg.scale};
      diff = $signed({value[63], value}) - $signed({sig_cfg.offset[63], sig_cfg.offset});
      dneg = diff[64];
      dmag = dneg ? -diff : diff;
      q = 64'(dmag / {32'd0, smag});
      if (q != 0 && dneg != sneg) begin
        if (sig_cfg.signed_raw) raw = -q;
        else begin
          raw = '0; r.status = ST_SAT;
        end
      end else raw = q;
      for (int i = 0; i < len; i++) begin
        pos = bit_position(i);
        idx = sig_cfg.big_endian ? len - 1 - i : i;
        if (pos >= 0) r.frame[pos] = raw[idx];
      end
      r.raw = widen_raw(raw, len);
    end
    return r;
  endfunction

  // register shadow, expectations on accepted items, compare on accepted results
  always @(posedge clk) begin
    signal_result_t got, want;
    if (rst) begin
      sig_cfg <= '{start_bit: '0, signal_length: '0, big_endian: 1'b0, signed_raw: 1'b0,
                   scale: SCALE_ONE, offset: '0};
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_BIT:  sig_cfg.start_bit     <= cfg_data[5:0];
          REG_SIG_LENGTH: sig_cfg.signal_length <= cfg_data[6:0];
          REG_BIG_ENDIAN: sig_cfg.big_endian    <= cfg_data[0];
          REG_SIGNED_RAW: sig_cfg.signed_raw    <= cfg_data[0];
          REG_SCALE:      sig_cfg.scale         <= cfg_data[31:0];
          REG_OFFSET:     sig_cfg.offset        <= cfg_data;
          default: ;
        endcase
      end
      if (in_item.valid && in_item.ready)
        expected_q.push_back(predict_signal(in_item.operation, in_item.frame_in,
                                            in_item.phys_value));
      if (out_item.valid && out_item.ready) begin
        got = '{phys: out_item.phys_out, raw: out_item.raw_out,
                frame: out_item.frame_out, status: out_item.status};
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (got.phys !== want.phys)
              $error("phys_out expected %h got %h", want.phys, got.phys);
            if (got.raw !== want.raw)
              $error("raw_out expected %h got %h", want.raw, got.raw);
            if (got.frame !== want.frame)
              $error("frame_out expected %h got %h", want.frame, got.frame);
            if (got.status !== want.status)
              $error("status expected %0d got %0d", want.status, got.status);
          end
        end
      end
    end
  end
endmodule

// ----- bench/tb_can_signal_extract_insert_core.sv -----
// testbench top: stimulus, register settings and verdict for the signal block
`timescale 1ns / 100ps
module tb_can_signal_extract_insert_core;
  import cse_pkg::*;

  logic clk, rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;
  int fail_count, pending;
  int hold_off;

  cse_in_if  in_ch();
  cse_out_if out_ch();

  can_signal_extract_insert_core u_top (
    .clk(clk), .rst(rst), .in_item(in_ch.sink), .out_item(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cse_scoreboard u_checker (
    .clk(clk), .rst(rst), .in_item(in_ch.sink), .out_item(out_ch.sink),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #30ms;
    $display("** can_signal_extract_insert_core: FAILED **");
    $finish;
  end

  // receiver: random stalls, one long hold-off when asked
  initial begin
    int gap;
    hold_off = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off = hold_off - 1;
      end else if (out_ch.valid && out_ch.ready) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
      end else out_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_signal(input int sb, input int len, input bit moto, input bit sgn,
                            input logic [31:0] scl, input logic [63:0] ofs);
    write_reg(REG_START_BIT, 64'(sb));
    write_reg(REG_SIG_LENGTH, 64'(len));
    write_reg(REG_BIG_ENDIAN, 64'(moto));
    write_reg(REG_SIGNED_RAW, 64'(sgn));
    write_reg(REG_SCALE, {32'd0, scl});
    write_reg(REG_OFFSET, ofs);
  endtask

  // stop offering, wait out all results plus the longest back-end latency
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // offer one item, with an optional random gap before it
  task automatic send_frame(input logic op, input logic [63:0] frame,
                            input logic [63:0] value, input bit gaps);
    int gap;
    gap = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op; in_ch.frame_in <= frame; in_ch.phys_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 3))
      0: return rand64();
      1: return 64'($signed($urandom_range(0, 2000) - 1000)) <<< 16;
      2: return {{32{$urandom_range(0, 1) == 1}}, $urandom};
      default: return {$urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                            : 64'h7FFF_FFFF_FFFF_FFFF} ^ 64'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return 32'h0001_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'd0;
      4: return 32'($signed($urandom_range(0, 64)) - 32) <<< 14;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [63:0] f;
    rst = 1'b1;
    cfg_we <= 1'b0; cfg_index <= REG_START_BIT; cfg_data <= '0;
    in_ch.valid <= 1'b0; in_ch.operation <= OP_EXTRACT;
    in_ch.frame_in <= '0; in_ch.phys_value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: length zero
    send_frame(OP_EXTRACT, 64'hDEAD_BEEF_0123_4567, '0, 1'b0);
    send_frame(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0005_0000, 1'b0);
    drain_block();

    // full 64-bit intel signal, unit gain, extremes
    set_signal(0, 64, 1'b0, 1'b1, 32'h0001_0000, '0);
    send_frame(OP_EXTRACT, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0);
    send_frame(OP_EXTRACT, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0);
    send_frame(OP_EXTRACT, 64'h8000_0000_0000_0000, '0, 1'b0);
    send_frame(OP_INSERT, '0, 64'h8000_0000_0000_0000, 1'b0);
    send_frame(OP_INSERT, '0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    drain_block();

    // motorola signal running off the frame end, unsigned, negative clamp
    set_signal(60, 16, 1'b1, 1'b0, 32'hFFFF_0000, 64'h0000_0000_0010_0000);
    send_frame(OP_EXTRACT, 64'hA5A5_5A5A_F0F0_0F0F, '0, 1'b0);
    send_frame(OP_INSERT, 64'h1234_5678_9ABC_DEF0, 64'h0000_0000_0040_0000, 1'b0);
    send_frame(OP_INSERT, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_FFF0_0000, 1'b0);
    drain_block();

    // zero scale, intel signal off the frame end, length above 64
    set_signal(63, 100, 1'b0, 1'b0, 32'd0, 64'h8000_0000_0000_0000);
    send_frame(OP_INSERT, 64'h0F0F_0F0F_0F0F_0F0F, 64'h1234, 1'b0);
    send_frame(OP_EXTRACT, 64'h8000_0000_0000_0000, '0, 1'b0);
    drain_block();

    // saturation at large gain
    set_signal(7, 64, 1'b1, 1'b0, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    send_frame(OP_EXTRACT, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0);
    send_frame(OP_EXTRACT, 64'h0000_0000_0000_0001, '0, 1'b0);
    drain_block();
    write_reg(REG_SCALE, 64'h8000_0000);
    write_reg(REG_OFFSET, 64'h8000_0000_0000_0000);
    send_frame(OP_EXTRACT, 64'h0000_0000_0000_00FF, '0, 1'b0);
    send_frame(OP_INSERT, 64'h0000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    drain_block();

    // random phases: new signal settings, then a burst of items
    for (int ph = 0; ph < 30; ph++) begin
      set_signal($urandom_range(0, 63),
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                             : $urandom_range(1, 24),
                 $urandom_range(0, 1), $urandom_range(0, 1), rand_scale(), rand_value());
      if (ph == 5) hold_off = 600;
      for (int n = 0; n < 30; n++) begin
        f = rand64();
        send_frame($urandom_range(0, 1), f, rand_value(), ph != 5 && (n % 10) > 2);
      end
      drain_block();
    end

    drain_block();
    if (fail_count == 0) $display("** can_signal_extract_insert_core: PASSED **");
    else $display("** can_signal_extract_insert_core: FAILED **");
    $finish;
  end
endmodule
